// ----- hw/rtl/sfcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_pkg
// Types, constants and CRC byte-update functions for the frame CRC checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam logic [7:0]  CRC8_INIT  = 8'hFF;
  localparam logic [7:0]  CRC8_POLY  = 8'h8C;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Word index of each configuration register (byte address / 4)
  localparam logic [0:0] REG_CRC_MODE = 1'b0;

  typedef enum logic {
    CRC_MODE_8  = 1'b0,
    CRC_MODE_16 = 1'b1
  } crc_mode_t;

  typedef struct packed {
    crc_mode_t crc_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] payload_crc;
    logic        crc_match;
    logic        frame_valid;
  } out_item_t;

  // Reflected CRC-8, one byte, unrolled over its eight bits
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-16, one byte, unrolled over its eight bits
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/sfcc_apb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_apb_regs
// APB-style register file holding the CRC mode selection.
// ----------------------------------------------------------------------------
module sfcc_apb_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfcc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sfcc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output sfcc_pkg::cfg_t                    cfg
);
  import sfcc_pkg::*;

  crc_mode_t  crc_mode_r;
  crc_mode_t  crc_mode_nxt;
  logic       reg_hit;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_CRC_MODE);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_comb begin
    crc_mode_nxt = crc_mode_r;
    if (wr_en) begin
      crc_mode_nxt = crc_mode_t'(pwdata[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= CRC_MODE_8;
    end else begin
      crc_mode_r <= crc_mode_nxt;
    end
  end

  assign prdata       = reg_hit ? {{(CFG_DATA_W-1){1'b0}}, crc_mode_r} : '0;
  assign cfg.crc_mode = crc_mode_r;

endmodule

// ----- hw/rtl/sfcc_frame_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_frame_core
// Per-frame state: running CRC, two-byte delay line and byte count; forms
// the result for the byte presented on the step.
// ----------------------------------------------------------------------------
module sfcc_frame_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfcc_pkg::cfg_t        cfg,
  input  logic                  step,
  input  sfcc_pkg::in_item_t    item,
  output sfcc_pkg::out_item_t   result
);
  import sfcc_pkg::*;

  logic [15:0] running_r, running_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] crc_upd;

  // Byte leaving the delay line enters the CRC
  always_comb begin
    crc_upd = running_r;
    unique case (cfg.crc_mode)
      CRC_MODE_8: begin
        if (count_r >= 2'd1) begin
          crc_upd = {8'h00, crc8_byte(running_r[7:0], held0_r)};
        end
      end
      CRC_MODE_16: begin
        if (count_r >= 2'd2) begin
          crc_upd = crc16_byte(running_r, held1_r);
        end
      end
      default: crc_upd = running_r;
    endcase
  end

  always_comb begin
    running_nxt = running_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    count_nxt   = count_r;
    result      = '0;
    if (step) begin
      if (!item.frame_end) begin
        running_nxt = crc_upd;
        held1_nxt   = held0_r;
        held0_nxt   = item.data_byte;
        count_nxt   = (count_r == 2'd3) ? count_r : count_r + 2'd1;
      end else begin
        result.frame_done = 1'b1;
        if (cfg.crc_mode == CRC_MODE_8) begin
          result.payload_crc = {8'h00, crc_upd[7:0]};
          result.crc_match   = (crc_upd[7:0] == item.data_byte);
        end else begin
          result.payload_crc = crc_upd;
          result.crc_match   = (crc_upd[7:0] == held0_r) &&
                               (crc_upd[15:8] == item.data_byte);
        end
        result.frame_valid = result.crc_match && (count_r >= 2'd2);
        running_nxt = CRC16_INIT;
        held0_nxt   = 8'h00;
        held1_nxt   = 8'h00;
        count_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= CRC16_INIT;
      held0_r   <= 8'h00;
      held1_r   <= 8'h00;
      count_r   <= 2'd0;
    end else begin
      running_r <= running_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/serial_frame_crc_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_crc_checker_top
// Frame CRC checker, CRC-8 (reflected 0x8C) or CRC-16 (reflected 0x8408).
// Path: each byte is held in the input register, then its CRC update is
//   written into the result register.
// Throughput: one byte per cycle unless out_stall holds the result; the
//   unrolled 8-bit CRC update sits in a single stage between the input and
//   result registers.
// Reset (rst_n low, synchronous): pipeline empty, CRC mode CRC-8, running
//   CRC all ones, delay line and byte count cleared.
// ----------------------------------------------------------------------------
module serial_frame_crc_checker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfcc_pkg::in_item_t                in_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfcc_pkg::out_item_t               out_item,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfcc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sfcc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import sfcc_pkg::*;

  cfg_t       cfg;
  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_item_r, s1_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  out_item_t  core_result;
  logic       out_free;
  logic       s1_adv;
  logic       in_xfer;

  sfcc_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // Input stage hands its byte to the core when the result slot frees up
  assign s1_adv   = s1_valid_r && out_free;
  // Stall only while the input register holds a byte that cannot advance
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // The core commits its state exactly on the cycle the byte advances
  sfcc_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (s1_adv),
    .item   (s1_item_r),
    .result (core_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = in_item;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = core_result;
    end else if (!out_stall) begin
      // drop the result once its transfer completes
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An advancing byte always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced byte did not produce a result");

  // Mid-frame results carry all-zero fields
  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.frame_done) |->
      (out_item_r.payload_crc == 16'h0000 && !out_item_r.crc_match &&
       !out_item_r.frame_valid))
    else $error("mid-frame result has nonzero fields");

  // A valid frame must also have a matching CRC
  a_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.frame_valid) |-> out_item_r.crc_match)
    else $error("frame_valid without crc_match");

  // Input is never stalled when the input register is empty
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
